// ===== hw/rtl/pls_pkg.sv =====
// Package for the positional list store.
// Holds operation codes and the command and status bundles shared by the controller
// and the datapath. Depends on nothing.
package pls_pkg;

    localparam int KIND_BITS = 2;
    localparam int POS_BITS  = 7;
    localparam int VAL_BITS  = 32;
    localparam int CNT_BITS  = 7;

    localparam logic [KIND_BITS-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd2;

    typedef struct packed {
        logic load;
        logic rd_pos;
        logic cap_rd;
        logic sh_wr;
        logic wr_val;
        logic commit;
        logic out_load;
    } pls_cmd_t;

    typedef struct packed {
        logic go_read;
        logic go_ins;
        logic go_rem;
        logic shift_more;
        logic out_free;
    } pls_status_t;

endpackage

// ===== hw/rtl/positional_list_store.sv =====
// Top level of the positional list store.
// Joins the controller and the datapath. Depends on pls_pkg, pls_ctrl and pls_datapath.
//
// An ordered list of up to DEPTH words held in a single-port-write, registered-read RAM.
// Each request reads, inserts or removes at a position and yields one result with a
// success flag, the read word and the fill count afterwards. One request is handled at
// a time. A failed request goes from CHECK to DONE, a read passes READ and RWAIT, an
// insert shifts count - position entries up and a remove count - position - 1 down, each
// through SHRD (RAM read), SHWR (RAM write) and CHECK (test for a further shift); an insert
// then writes its word in WRITE. A new request is accepted in the cycle after the result
// is loaded, even while that result waits. The RAM needs no clearing after reset.
module positional_list_store
    import pls_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [KIND_BITS-1:0]        kind,
    input  logic [POS_BITS-1:0]         position,
    input  logic signed [VAL_BITS-1:0]  value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        ok,
    output logic signed [VAL_BITS-1:0]  read_value,
    output logic [CNT_BITS-1:0]         count
);

    pls_cmd_t    cmd;
    pls_status_t status;

    pls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pls_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .kind       (kind),
        .position   (position),
        .value      (value),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ok         (ok),
        .read_value (read_value),
        .count      (count)
    );

    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(cmd.sh_wr || cmd.wr_val || cmd.commit))
        else $error("RAM write or count update while idle");

    a_result_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("Result loaded over one not yet taken");

    a_fail_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (read_value == '0))
        else $error("Failed request returned nonzero data");

    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({status.go_read, status.go_ins, status.go_rem}))
        else $error("More than one operation active");

endmodule

// ===== hw/rtl/pls_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/pls_ctrl.sv =====
// Sequencer of the positional list store.
// Steps each request through its read, shift and write phases.
// Depends on pls_pkg for the command and status bundles.
module pls_ctrl
    import pls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pls_status_t status,
    output pls_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_RWAIT = 8'b0000_1000,
        S_SHRD  = 8'b0001_0000,
        S_SHWR  = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.go_read)
                begin
                    state_next = S_READ;
                end
                else if ((status.go_ins || status.go_rem) && status.shift_more)
                begin
                    state_next = S_SHRD;
                end
                else if (status.go_ins)
                begin
                    state_next = S_WRITE;
                end
                else if (status.go_rem)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.rd_pos = 1'b1;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                cmd.cap_rd = 1'b1;
                state_next = S_DONE;
            end
            S_SHRD:
            begin
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = S_CHECK;
            end
            S_WRITE:
            begin
                cmd.wr_val = 1'b1;
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== hw/rtl/pls_datapath.sv =====
// Datapath of the positional list store: request registers, fill count, shift index,
// the entry RAM and the result register. Depends on pls_pkg and pls_ram.
module pls_datapath
    import pls_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [KIND_BITS-1:0]        kind,
    input  logic [POS_BITS-1:0]         position,
    input  logic signed [VAL_BITS-1:0]  value,
    input  pls_cmd_t                    cmd,
    output pls_status_t                 status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        ok,
    output logic signed [VAL_BITS-1:0]  read_value,
    output logic [CNT_BITS-1:0]         count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_BITS) ? CW : POS_BITS;

    logic [CW-1:0]        count_reg;
    logic [AW-1:0]        pos_reg;
    logic [AW-1:0]        idx_reg;
    logic [WORD_BITS-1:0] val_reg;
    logic [WORD_BITS-1:0] rd_reg;
    logic                 go_read_reg;
    logic                 go_ins_reg;
    logic                 go_rem_reg;
    logic                 out_valid_reg;
    logic                 ok_reg;
    logic [VAL_BITS-1:0]  rv_reg;
    logic [CNT_BITS-1:0]  cnt_out_reg;

    logic [XW-1:0]        pos_x;
    logic [XW-1:0]        cnt_x;
    logic                 rd_ok;
    logic                 ins_ok;
    logic                 rem_ok;
    logic [AW-1:0]        ram_raddr;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;
    logic                 ram_we;

    assign pos_x  = XW'(position);
    assign cnt_x  = XW'(count_reg);
    assign rd_ok  = (kind == KIND_READ) && (pos_x < cnt_x);
    assign ins_ok = (kind == KIND_INSERT) && (pos_x <= cnt_x) && (cnt_x < XW'(DEPTH));
    assign rem_ok = (kind == KIND_REMOVE) && (pos_x < cnt_x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            go_read_reg   <= 1'b0;
            go_ins_reg    <= 1'b0;
            go_rem_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                go_read_reg <= rd_ok;
                go_ins_reg  <= ins_ok;
                go_rem_reg  <= rem_ok;
            end
            if (cmd.commit)
            begin
                count_reg <= go_ins_reg ? count_reg + CW'(1) : count_reg - CW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_reg <= AW'(position);
            val_reg <= WORD_BITS'(value);
            idx_reg <= (kind == KIND_INSERT) ? AW'(count_reg) : AW'(position);
        end
        if (cmd.sh_wr)
        begin
            idx_reg <= go_ins_reg ? idx_reg - AW'(1) : idx_reg + AW'(1);
        end
        if (cmd.cap_rd)
        begin
            rd_reg <= ram_rdata;
        end
        if (cmd.out_load)
        begin
            ok_reg      <= go_read_reg || go_ins_reg || go_rem_reg;
            rv_reg      <= go_read_reg ? VAL_BITS'(rd_reg) : '0;
            cnt_out_reg <= CNT_BITS'(count_reg);
        end
    end

    always_comb
    begin
        if (cmd.rd_pos)
        begin
            ram_raddr = pos_reg;
        end
        else if (go_ins_reg)
        begin
            ram_raddr = idx_reg - AW'(1);
        end
        else
        begin
            ram_raddr = idx_reg + AW'(1);
        end
    end

    assign ram_we    = cmd.sh_wr || cmd.wr_val;
    assign ram_waddr = cmd.wr_val ? pos_reg : idx_reg;
    assign ram_wdata = cmd.wr_val ? val_reg : ram_rdata;

    pls_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status.go_read    = go_read_reg;
    assign status.go_ins     = go_ins_reg;
    assign status.go_rem     = go_rem_reg;
    assign status.shift_more = go_ins_reg ? (idx_reg > pos_reg)
                                          : ((CW'(idx_reg) + CW'(1)) < count_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign read_value = $signed(rv_reg);
    assign count      = cnt_out_reg;

endmodule
